/* design/adcavg_pkg.sv */
// adcavg_pkg: shared widths, constants, register indexes, payload structs
// and the panel outlet map for the converter average/deadband conditioner.
// No dependencies.
package adcavg_pkg;

   // default sizes handed to the top level parameters
   localparam int CHANNEL_COUNT_DEF     = 8;
   localparam int MAX_AVERAGE_SHIFT_DEF = 4;

   // field widths
   localparam int CH_W     = 3;
   localparam int BYTE_W   = 8;
   localparam int NIBBLE_W = 4;
   localparam int CODE_W   = 12;
   localparam int SUM_W    = 16;
   localparam int OUTLET_W = 4;
   localparam int PASS_W   = 4;
   localparam int SHIFT_W  = 3;
   localparam int DB_W     = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 3;
   localparam int ACTIVE_W   = 4;

   // arithmetic constants
   localparam logic [CODE_W-1:0]   SCALE_TOP    = 12'd4001;
   localparam logic [DB_W-1:0]     DEADBAND_MAX = 3'd5;
   localparam logic [ACTIVE_W-1:0] BASE_ACTIVE  = 4'd6;
   localparam logic [SUM_W-1:0]    SUM_MAX      = 16'hffff;

   // register indexes on the csr channel
   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_AVERAGE_SHIFT  = 2'd0;
   localparam csr_index_type CSR_DEADBAND_WIDTH = 2'd1;
   localparam csr_index_type CSR_BOARD_VARIANT  = 2'd2;

   typedef struct packed {
      logic [CH_W-1:0]   channel_index;
      logic [BYTE_W-1:0] response_high;
      logic [BYTE_W-1:0] response_low;
   } req_item_type;

   typedef struct packed {
      logic [CH_W-1:0]     result_channel;
      logic [OUTLET_W-1:0] panel_outlet;
      logic [CODE_W-1:0]   conditioned_value;
      logic                last_of_round;
   } rsp_item_type;

   typedef struct packed {
      logic [SHIFT_W-1:0] average_shift;
      logic [DB_W-1:0]    deadband_width;
      logic               board_variant;
   } cfg_type;

   // panel outlet for the eight-channel board
   function automatic logic [OUTLET_W-1:0] panel_map(input logic [CH_W-1:0] ch);
      logic [OUTLET_W-1:0] outlet;
      unique case (ch)
         3'd0: outlet = 4'd6;
         3'd1: outlet = 4'd3;
         3'd2: outlet = 4'd8;
         3'd3: outlet = 4'd7;
         3'd4: outlet = 4'd4;
         3'd5: outlet = 4'd1;
         3'd6: outlet = 4'd2;
         3'd7: outlet = 4'd5;
         default: outlet = 4'd1;
      endcase
      return outlet;
   endfunction

endpackage

/* design/adcavg_if.sv */
// adcavg_if: valid/ready channel interfaces for requests, results and csr writes.
// Depends on adcavg_pkg for field widths.
interface adcavg_req_if
   import adcavg_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [CH_W-1:0]   channel_index;
   logic [BYTE_W-1:0] response_high;
   logic [BYTE_W-1:0] response_low;

   modport source (output valid, channel_index, response_high, response_low, input ready);
   modport sink   (input valid, channel_index, response_high, response_low, output ready);
endinterface

interface adcavg_rsp_if
   import adcavg_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [CH_W-1:0]     result_channel;
   logic [OUTLET_W-1:0] panel_outlet;
   logic [CODE_W-1:0]   conditioned_value;
   logic                last_of_round;

   modport source (output valid, result_channel, panel_outlet, conditioned_value,
                   last_of_round, input ready);
   modport sink   (input valid, result_channel, panel_outlet, conditioned_value,
                   last_of_round, output ready);
endinterface

interface adcavg_csr_if
   import adcavg_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* design/adcavg_chan_proc.sv */
// adcavg_chan_proc: per-channel sum, pass counter and deadband hold state,
// with the update for one response. Depends on adcavg_pkg.
module adcavg_chan_proc
   import adcavg_pkg::*;
#(
   parameter int CHANNEL_COUNT     = CHANNEL_COUNT_DEF,
   parameter int MAX_AVERAGE_SHIFT = MAX_AVERAGE_SHIFT_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   input  cfg_type      cfg,
   output logic         produce,
   output rsp_item_type result
);

   localparam logic [ACTIVE_W-1:0] FULL_ACTIVE = ACTIVE_W'(CHANNEL_COUNT);
   localparam logic [SHIFT_W-1:0]  SHIFT_CAP   = SHIFT_W'(MAX_AVERAGE_SHIFT);

   logic [SUM_W-1:0]  sums_ff [CHANNEL_COUNT];
   logic [SUM_W-1:0]  sums_in;
   logic [CODE_W-1:0] held_ff [CHANNEL_COUNT];
   logic [CODE_W-1:0] held_in;
   logic [PASS_W-1:0] pass_ff;
   logic [PASS_W-1:0] pass_in;

   logic [CH_W-1:0]     ch;
   logic [CODE_W-1:0]   code;
   logic [ACTIVE_W-1:0] active;
   logic [SHIFT_W-1:0]  shift;
   logic [DB_W-1:0]     db;
   logic                is_active;
   logic                last;
   logic [PASS_W:0]     pass_limit;
   logic                final_pass;
   logic [SUM_W:0]      sum_wide;
   logic [SUM_W-1:0]    sum_sat;
   logic [SUM_W-1:0]    avg;
   logic [CODE_W-1:0]   value_clamp;
   logic signed [SUM_W+1:0] fresh;
   logic signed [SUM_W+1:0] diff;
   logic signed [SUM_W+1:0] db_s;
   logic                change;
   logic                held_write;

   // decode the beat and the live configuration
   always_comb begin
      ch        = item.channel_index;
      code      = {item.response_high[NIBBLE_W-1:0], item.response_low};
      active    = cfg.board_variant ? FULL_ACTIVE : BASE_ACTIVE;
      shift     = (cfg.average_shift > SHIFT_CAP) ? SHIFT_CAP : cfg.average_shift;
      db        = (cfg.deadband_width > DEADBAND_MAX) ? DEADBAND_MAX : cfg.deadband_width;
      is_active = {1'b0, ch} < active;
      last      = {1'b0, ch} == (active - 4'd1);
   end

   // pass tracking: final pass once count reaches 2^shift - 1
   always_comb begin
      pass_limit = ((PASS_W+1)'(1) << shift) - (PASS_W+1)'(1);
      final_pass = pass_ff >= pass_limit[PASS_W-1:0];
      if (final_pass) begin
         pass_in = '0;
      end else begin
         pass_in = pass_ff + 4'd1;
      end
   end

   // saturating accumulate, average, invert and clamp
   always_comb begin
      sum_wide = {1'b0, sums_ff[ch]} + (SUM_W+1)'(code);
      sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
      avg      = sum_sat >> shift;
      if (avg >= SUM_W'(SCALE_TOP)) begin
         value_clamp = '0;
      end else begin
         value_clamp = SCALE_TOP - avg[CODE_W-1:0];
      end
      sums_in = final_pass ? '0 : sum_sat;
   end

   // deadband: compare unclamped inversion against the held value
   always_comb begin
      fresh  = $signed({2'b00, SUM_W'(SCALE_TOP)}) - $signed({2'b00, avg});
      diff   = fresh - $signed({(SUM_W+2-CODE_W)'(0), held_ff[ch]});
      db_s   = $signed({(SUM_W+2-DB_W)'(0), db});
      change = (diff > db_s) || (diff < -db_s);
      held_write = (db != '0) && change;
      held_in    = value_clamp;
   end

   // result beat
   always_comb begin
      produce                  = is_active && final_pass;
      result.result_channel    = ch;
      result.panel_outlet      = cfg.board_variant ? panel_map(ch)
                                                   : OUTLET_W'(ch) + 4'd1;
      result.conditioned_value = ((db != '0) && !change) ? held_ff[ch] : value_clamp;
      result.last_of_round     = last;
   end

   // state update
   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff <= '0;
         for (int i = 0; i < CHANNEL_COUNT; i++) begin
            sums_ff[i] <= '0;
            held_ff[i] <= '0;
         end
      end else if (fire && is_active) begin
         sums_ff[ch] <= sums_in;
         if (last) begin
            pass_ff <= pass_in;
         end
         if (final_pass && held_write) begin
            held_ff[ch] <= held_in;
         end
      end
   end

endmodule

/* design/adc_average_deadband_conditioner.sv */
// adc_average_deadband_conditioner: converter response averaging with deadband hold.
// An accepted request sits in the input register; its result, if produced, then sits in the result register on rsp.
// Throughput: one request per cycle while rsp is not stalled; channel state is updated as a beat advances.
// A result held on rsp stalls the input register and then req until it is taken.
// Reset (synchronous, active high) clears valid flags, config, sums, held values, pass count.
// Depends on adcavg_pkg, adcavg_if and adcavg_chan_proc.
module adc_average_deadband_conditioner
   import adcavg_pkg::*;
#(
   parameter int CHANNEL_COUNT     = CHANNEL_COUNT_DEF,
   parameter int MAX_AVERAGE_SHIFT = MAX_AVERAGE_SHIFT_DEF
) (
   input  logic         clock,
   input  logic         reset,
   adcavg_req_if.sink   req_chan,
   adcavg_rsp_if.source rsp_chan,
   adcavg_csr_if.sink   csr_chan
);

   cfg_type      cfg_ff;
   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff;
   logic         advance;
   logic         produce;
   rsp_item_type result;

   // csr writes are always taken
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_AVERAGE_SHIFT:  cfg_ff.average_shift  <= csr_chan.data;
            CSR_DEADBAND_WIDTH: cfg_ff.deadband_width <= csr_chan.data;
            CSR_BOARD_VARIANT:  cfg_ff.board_variant  <= csr_chan.data[0];
            default: ;
         endcase
      end
   end

   // input register moves on whenever the result register frees up
   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_item_ff.channel_index <= req_chan.channel_index;
         in_item_ff.response_high <= req_chan.response_high;
         in_item_ff.response_low  <= req_chan.response_low;
      end
   end

   adcavg_chan_proc #(
      .CHANNEL_COUNT     (CHANNEL_COUNT),
      .MAX_AVERAGE_SHIFT (MAX_AVERAGE_SHIFT)
   ) u_chan_proc (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .item    (in_item_ff),
      .cfg     (cfg_ff),
      .produce (produce),
      .result  (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= produce;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && produce) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.result_channel    = rsp_item_ff.result_channel;
   assign rsp_chan.panel_outlet      = rsp_item_ff.panel_outlet;
   assign rsp_chan.conditioned_value = rsp_item_ff.conditioned_value;
   assign rsp_chan.last_of_round     = rsp_item_ff.last_of_round;

`ifndef SYNTHESIS
   // reported values never exceed the inversion top
   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_item_ff.conditioned_value <= SCALE_TOP))
      else $error("conditioned value above scale top");

   // outlet numbers start at one
   a_outlet_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_item_ff.panel_outlet != '0))
      else $error("panel outlet zero");

   // requests back up only when both stages hold a stalled beat
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (in_valid_ff && rsp_valid_ff && !rsp_chan.ready))
      else $error("request stalled without a full pipeline");

   // a beat handed to the result register is visible next cycle
   a_result_load: assert property (@(posedge clock) disable iff (reset)
      (advance && produce) |=> rsp_valid_ff)
      else $error("produced result lost");
`endif

endmodule
